>>> hw/rtl/gdps_pkg.sv
// Shared constants, command codes and controller/datapath bundles for the
// grid depth-first path search unit. No dependencies.
package gdps_pkg;

	// Grid geometry
	localparam int GRID_SIDE = 32;
	localparam int CELLS     = GRID_SIDE * GRID_SIDE;
	localparam int CELL_W    = $clog2(CELLS);
	localparam int DEPTH_W   = $clog2(CELLS + 1);

	// Fixed port widths
	localparam int COORD_W   = 5;
	localparam int IDX_W     = 10;
	localparam int CMD_W     = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 5;
	localparam int DIR_W     = 2;
	localparam int DCNT_W    = DIR_W + 1;
	localparam int ENTRY_W   = 2 * COORD_W;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_END_ROW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_COL = 1'd1;

	localparam logic [COORD_W-1:0] END_ROW_RST = 5'd24;
	localparam logic [COORD_W-1:0] END_COL_RST = 5'd25;

	// Neighbor directions, tried in this order
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic fill;      // write wall bit 1 at sweep counter
		logic wr_cell;   // write one wall bit from the input beat
		logic ld_solve;  // load start cell, reset path
		logic ld_read;   // issue path entry read
		logic clr;       // clear visited bit at sweep counter
		logic mark;      // mark current cell visited
		logic hit;       // set found
		logic dinc;      // advance direction
		logic nbrd;      // read neighbor wall and visited bits
		logic push;      // push neighbor onto the path
		logic pop;       // drop top entry, read new top
		logic popld;     // load new top and its next direction
		logic rdout;     // emit path read result
		logic fin;       // emit result with zero coordinates
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic start_ok;  // input cell inside the grid
		logic cnt_last;  // sweep counter at last cell
		logic at_end;    // current cell is the target
		logic d_done;    // all four directions tried
		logic nb_ok;     // neighbor inside the grid
		logic can_push;  // neighbor open, unvisited, stack not full
		logic depth_le1; // at most one entry on the path
	} sts_t;

	// Linear cell address from row and column
	function automatic logic [CELL_W-1:0] cell_addr(
		input logic [COORD_W-1:0] r,
		input logic [COORD_W-1:0] c
	);
		logic [2*CELL_W-1:0] prod;
		prod = (2*CELL_W)'(r) * (2*CELL_W)'(GRID_SIDE);
		return prod[CELL_W-1:0] + CELL_W'(c);
	endfunction

endpackage

>>> hw/rtl/gdps_ctrl.sv
// Sequencer for the grid path search unit: command decode, reset fill,
// visited clear sweep and the depth-first walk. Depends on gdps_pkg.
module gdps_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [gdps_pkg::CMD_W-1:0] cmd,
	input  gdps_pkg::sts_t            sts,
	output gdps_pkg::ctl_t            ctl,
	output logic                      busy
);
	import gdps_pkg::*;

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_CLEAR = 3'd2;
	localparam logic [2:0] S_ENTER = 3'd3;
	localparam logic [2:0] S_STEP  = 3'd4;
	localparam logic [2:0] S_EVAL  = 3'd5;
	localparam logic [2:0] S_POP   = 3'd6;
	localparam logic [2:0] S_READ  = 3'd7;

	logic [2:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	// Decode state and status into datapath commands
	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				ctl.fill = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					case (cmd)
						CMD_WRITE: begin
							ctl.wr_cell = 1'b1;
							ctl.fin     = 1'b1;
						end
						CMD_SOLVE: begin
							ctl.ld_solve = 1'b1;
							if (sts.start_ok) begin
								state_d = S_CLEAR;
							end else begin
								ctl.fin = 1'b1;
							end
						end
						CMD_READ: begin
							ctl.ld_read = 1'b1;
							state_d     = S_READ;
						end
						default: begin
							ctl.fin = 1'b1;
						end
					endcase
				end
			end
			S_CLEAR: begin
				ctl.clr = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_ENTER;
				end
			end
			S_ENTER: begin
				if (sts.at_end) begin
					ctl.hit = 1'b1;
					ctl.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					ctl.mark = 1'b1;
					state_d  = S_STEP;
				end
			end
			S_STEP: begin
				if (!sts.d_done) begin
					if (sts.nb_ok) begin
						ctl.nbrd = 1'b1;
						state_d  = S_EVAL;
					end else begin
						ctl.dinc = 1'b1;
					end
				end else if (sts.depth_le1) begin
					ctl.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					ctl.pop = 1'b1;
					state_d = S_POP;
				end
			end
			S_EVAL: begin
				if (sts.can_push) begin
					ctl.push = 1'b1;
					state_d  = S_ENTER;
				end else begin
					ctl.dinc = 1'b1;
					state_d  = S_STEP;
				end
			end
			S_POP: begin
				ctl.popld = 1'b1;
				state_d   = S_STEP;
			end
			S_READ: begin
				ctl.rdout = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; reset starts the wall fill sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Neighbor evaluation always follows the read issued in a step
	a_eval_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> $past(state_q) == S_STEP)
		else $error("eval state entered without a neighbor read");

	// A pop load always follows the pop that issued the stack read
	a_popld_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> $past(ctl.pop))
		else $error("pop load without a preceding pop");

endmodule

>>> hw/rtl/gdps_dp.sv
// Datapath for the grid path search unit: wall, visited, path and direction
// memories, walk registers, configuration and result registers. Uses gdps_pkg.
module gdps_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gdps_pkg::ctl_t                ctl,
	output gdps_pkg::sts_t                sts,
	input  logic [gdps_pkg::COORD_W-1:0]  row,
	input  logic [gdps_pkg::COORD_W-1:0]  col,
	input  logic                          wall,
	input  logic [gdps_pkg::IDX_W-1:0]    path_index,
	input  logic                          cfg_we,
	input  logic [gdps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gdps_pkg::CFG_W-1:0]    cfg_data,
	output logic                          done,
	output logic                          found,
	output logic [gdps_pkg::DEPTH_W-1:0]  path_length,
	output logic [gdps_pkg::COORD_W-1:0]  path_row,
	output logic [gdps_pkg::COORD_W-1:0]  path_col
);
	import gdps_pkg::*;

	// Memories
	logic                wall_mem [CELLS];
	logic                vis_mem  [CELLS];
	logic [ENTRY_W-1:0]  path_mem [CELLS];
	logic [DIR_W-1:0]    dir_mem  [CELLS];

	// Control registers
	logic [COORD_W-1:0]  end_row_q, end_col_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic                found_q;
	logic [DCNT_W-1:0]   d_q;
	logic [CELL_W-1:0]   cnt_q;
	logic                done_q;
	logic [COORD_W-1:0]  prow_q, pcol_q;

	// Payload registers
	logic [COORD_W-1:0]  cur_row_q, cur_col_q;
	logic [IDX_W-1:0]    idx_q;
	logic                wall_rd_q, vis_rd_q;
	logic [ENTRY_W-1:0]  path_rd_q;
	logic [DIR_W-1:0]    dir_rd_q;

	// Derived signals
	logic [COORD_W-1:0]  nb_row, nb_col;
	logic                nb_ok, in_ok;
	logic [DEPTH_W-1:0]  dm1, dm2;
	logic [CELL_W-1:0]   cur_addr, nb_addr, in_addr;

	logic                wall_we, wall_wd, vis_we, vis_wd, path_we, path_re;
	logic [CELL_W-1:0]   wall_wa, vis_wa, path_wa, path_ra;
	logic [ENTRY_W-1:0]  path_wd;

	// Neighbor of the current cell in the direction under test
	always_comb begin
		nb_row = cur_row_q;
		nb_col = cur_col_q;
		nb_ok  = 1'b0;
		case (d_q[DIR_W-1:0])
			DIR_RIGHT: begin
				nb_col = cur_col_q + COORD_W'(1);
				nb_ok  = int'(cur_col_q) < GRID_SIDE - 1;
			end
			DIR_DOWN: begin
				nb_row = cur_row_q + COORD_W'(1);
				nb_ok  = int'(cur_row_q) < GRID_SIDE - 1;
			end
			DIR_LEFT: begin
				nb_col = cur_col_q - COORD_W'(1);
				nb_ok  = cur_col_q != '0;
			end
			DIR_UP: begin
				nb_row = cur_row_q - COORD_W'(1);
				nb_ok  = cur_row_q != '0;
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	assign in_ok    = (int'(row) < GRID_SIDE) && (int'(col) < GRID_SIDE);
	assign cur_addr = cell_addr(cur_row_q, cur_col_q);
	assign nb_addr  = cell_addr(nb_row, nb_col);
	assign in_addr  = cell_addr(row, col);
	assign dm1      = depth_q - DEPTH_W'(1);
	assign dm2      = depth_q - DEPTH_W'(2);

	// Status toward the sequencer
	assign sts.start_ok  = in_ok;
	assign sts.cnt_last  = cnt_q == CELL_W'(CELLS - 1);
	assign sts.at_end    = (cur_row_q == end_row_q) && (cur_col_q == end_col_q);
	assign sts.d_done    = d_q[DIR_W];
	assign sts.nb_ok     = nb_ok;
	assign sts.can_push  = !wall_rd_q && !vis_rd_q && (depth_q < DEPTH_W'(CELLS));
	assign sts.depth_le1 = depth_q <= DEPTH_W'(1);

	// Wall map: reset fill and cell writes share one write port
	assign wall_we = ctl.fill | (ctl.wr_cell & in_ok);
	assign wall_wa = ctl.fill ? cnt_q : in_addr;
	assign wall_wd = ctl.fill | wall;

	always_ff @(posedge clk) begin
		if (wall_we) begin
			wall_mem[wall_wa] <= wall_wd;
		end
		if (ctl.nbrd) begin
			wall_rd_q <= wall_mem[nb_addr];
		end
	end

	// Visited map: clear sweep and marking share one write port
	assign vis_we = ctl.clr | ctl.mark;
	assign vis_wa = ctl.clr ? cnt_q : cur_addr;
	assign vis_wd = ctl.mark;

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_wa] <= vis_wd;
		end
		if (ctl.nbrd) begin
			vis_rd_q <= vis_mem[nb_addr];
		end
	end

	// Path stack: start cell or pushed neighbor in, entry reads or new top out
	assign path_we = ctl.ld_solve | ctl.push;
	assign path_wa = ctl.push ? depth_q[CELL_W-1:0] : '0;
	assign path_wd = ctl.push ? {nb_row, nb_col} : {row, col};
	assign path_re = ctl.ld_read | ctl.pop;
	assign path_ra = ctl.ld_read ? CELL_W'(path_index) : dm2[CELL_W-1:0];

	always_ff @(posedge clk) begin
		if (path_we) begin
			path_mem[path_wa] <= path_wd;
		end
		if (path_re) begin
			path_rd_q <= path_mem[path_ra];
		end
	end

	// Direction stack: direction taken out of each path entry
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			dir_mem[dm1[CELL_W-1:0]] <= d_q[DIR_W-1:0];
		end
		if (ctl.pop) begin
			dir_rd_q <= dir_mem[dm2[CELL_W-1:0]];
		end
	end

	// Current cell and read index
	always_ff @(posedge clk) begin
		if (ctl.ld_solve) begin
			cur_row_q <= row;
			cur_col_q <= col;
		end else if (ctl.push) begin
			cur_row_q <= nb_row;
			cur_col_q <= nb_col;
		end else if (ctl.popld) begin
			cur_row_q <= path_rd_q[ENTRY_W-1:COORD_W];
			cur_col_q <= path_rd_q[COORD_W-1:0];
		end
		if (ctl.ld_read) begin
			idx_q <= path_index;
		end
	end

	// Walk state, configuration and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_row_q <= END_ROW_RST;
			end_col_q <= END_COL_RST;
			depth_q   <= '0;
			found_q   <= 1'b0;
			d_q       <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			prow_q    <= '0;
			pcol_q    <= '0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					REG_END_ROW: end_row_q <= cfg_data;
					REG_END_COL: end_col_q <= cfg_data;
					default: begin
						end_row_q <= end_row_q;
					end
				endcase
			end

			// sweep counter for reset fill and visited clear
			if (ctl.ld_solve) begin
				cnt_q <= '0;
			end else if (ctl.fill | ctl.clr) begin
				cnt_q <= sts.cnt_last ? '0 : cnt_q + CELL_W'(1);
			end

			// path depth and found flag
			if (ctl.ld_solve) begin
				depth_q <= in_ok ? DEPTH_W'(1) : '0;
				found_q <= 1'b0;
			end else if (ctl.push) begin
				depth_q <= depth_q + DEPTH_W'(1);
			end else if (ctl.pop) begin
				depth_q <= dm1;
			end
			if (ctl.hit) begin
				found_q <= 1'b1;
			end

			// direction under test
			if (ctl.ld_solve | ctl.push) begin
				d_q <= '0;
			end else if (ctl.dinc) begin
				d_q <= d_q + DCNT_W'(1);
			end else if (ctl.popld) begin
				d_q <= DCNT_W'(dir_rd_q) + DCNT_W'(1);
			end

			// result beat
			done_q <= ctl.fin | ctl.rdout;
			if (ctl.fin) begin
				prow_q <= '0;
				pcol_q <= '0;
			end else if (ctl.rdout) begin
				if (DEPTH_W'(idx_q) < depth_q) begin
					prow_q <= path_rd_q[ENTRY_W-1:COORD_W];
					pcol_q <= path_rd_q[COORD_W-1:0];
				end else begin
					prow_q <= '0;
					pcol_q <= '0;
				end
			end
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign path_length = depth_q;
	assign path_row    = prow_q;
	assign path_col    = pcol_q;

	// A push grows the path by exactly one entry
	a_push_depth: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> depth_q == $past(depth_q) + DEPTH_W'(1))
		else $error("push did not grow the path by one");

	// A pop only happens with at least two entries and shrinks by one
	a_pop_depth: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> depth_q > DEPTH_W'(1) ##1 depth_q == $past(depth_q) - DEPTH_W'(1))
		else $error("pop with a short path or wrong depth");

	// Found is only set while standing on the target cell
	a_hit_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.hit |-> sts.at_end && depth_q != '0)
		else $error("found set away from the target cell");

endmodule

>>> hw/rtl/grid_dfs_path_search_unit.sv
// Grid depth-first path search unit: top level joining sequencer and datapath.
// Depends on gdps_pkg, gdps_ctrl and gdps_dp.
//
// Usage: a command beat is taken when start is high and busy is low. cmd
// selects a wall write (row, col, wall), a solve from start cell (row, col)
// or a read of path entry path_index. Every command gives one result beat,
// marked by done for one cycle; the receiver cannot stall it.
// Wall write: the result beat follows in the next cycle and busy stays low,
// so writes go at one per cycle. Path read: the entry is read into a register
// while busy is high in the read state, then the result beat is registered.
// Solve: a sweep over every cell clears the visited map, then the walk
// marks each cell it enters, reads and then evaluates each in-grid neighbor,
// skips off-grid directions and backtracks through a pop and a pop load,
// ending on the target or when all directions of the start cell are tried.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write the target
// row (index 0) and column (index 1); cfg_ready is always high.
// Reset: arst_n clears control state and starts a fill sweep that sets
// every cell to wall; busy stays high until it completes.
module grid_dfs_path_search_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [gdps_pkg::CMD_W-1:0]     cmd,
	input  logic [gdps_pkg::COORD_W-1:0]   row,
	input  logic [gdps_pkg::COORD_W-1:0]   col,
	input  logic                           wall,
	input  logic [gdps_pkg::IDX_W-1:0]     path_index,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gdps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gdps_pkg::CFG_W-1:0]     cfg_data,
	output logic                           done,
	output logic                           found,
	output logic [gdps_pkg::DEPTH_W-1:0]   path_length,
	output logic [gdps_pkg::COORD_W-1:0]   path_row,
	output logic [gdps_pkg::COORD_W-1:0]   path_col
);
	import gdps_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic cfg_we;

	// Configuration is always accepted
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	gdps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	gdps_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.row         (row),
		.col         (col),
		.wall        (wall),
		.path_index  (path_index),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.found       (found),
		.path_length (path_length),
		.path_row    (path_row),
		.path_col    (path_col)
	);

endmodule
